// ===== sv/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the piecewise linear calibration block.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int DEF_MAX_POINTS = 32;

  localparam int X_W    = 16;
  localparam int Y_W    = 24;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;
  localparam int REG_W  = 2;
  localparam int DY_W   = Y_W + 1;
  localparam int PROD_W = DY_W + X_W + 1;
  localparam int DVD_W  = Y_W + X_W;
  localparam int Q_W    = Y_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [REG_W-1:0] REGION_BELOW  = 2'd0;
  localparam logic [REG_W-1:0] REGION_INSIDE = 2'd1;
  localparam logic [REG_W-1:0] REGION_ABOVE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_CHK_FIRST,
    ST_SCAN,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FIN
  } plc_state_t;

endpackage

// ===== sv/plc_div.sv =====
// ----------------------------------------------------------------------------
// plc_div
// Restoring divider, one quotient bit per cycle. Expects dividend < divisor
// shifted up by the quotient width, so the quotient fits Q_W bits.
// ----------------------------------------------------------------------------
module plc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [plc_pkg::DVD_W-1:0]      dividend,
  input  logic [plc_pkg::X_W-1:0]        divisor,
  output logic                           done,
  output logic [plc_pkg::Q_W-1:0]        quotient
);

  localparam int CW = $clog2(plc_pkg::Q_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(plc_pkg::Q_W - 1);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [plc_pkg::X_W-1:0]   rem_r, rem_nxt;
  logic [plc_pkg::X_W-1:0]   dv_r, dv_nxt;
  logic [plc_pkg::Q_W-1:0]   dvd_r, dvd_nxt;
  logic [plc_pkg::X_W:0]     trial;
  logic                      ge;

  assign trial = {rem_r, dvd_r[plc_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, dv_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[plc_pkg::DVD_W-1:plc_pkg::Q_W];
      dvd_nxt  = dividend[plc_pkg::Q_W-1:0];
      dv_nxt   = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? plc_pkg::X_W'(trial - {1'b0, dv_r}) : trial[plc_pkg::X_W-1:0];
      dvd_nxt = {dvd_r[plc_pkg::Q_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== sv/piecewise_linear_calibration.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_calibration
// Breakpoint table with clamped linear interpolation between points.
// ----------------------------------------------------------------------------
// A load item writes one breakpoint and gives no result. A query item reads
// the last active point and the first point and stops there when the input
// is clamped below or above the table; otherwise it scans the table one
// entry per cycle from the bottom, then multiplies once and runs a restoring
// shift-subtract divider. The table has a single read port. in_ready is low
// while a query is in work.
module piecewise_linear_calibration #(
  parameter int MAX_POINTS = plc_pkg::DEF_MAX_POINTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [plc_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [plc_pkg::IDX_W-1:0]         in_point_index,
  input  logic [plc_pkg::X_W-1:0]           in_point_x,
  input  logic signed [plc_pkg::Y_W-1:0]    in_point_y,
  input  logic [plc_pkg::X_W-1:0]           in_query_x,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [plc_pkg::Y_W-1:0]    out_result_y,
  output logic [plc_pkg::IDX_W-1:0]         out_segment,
  output logic [plc_pkg::REG_W-1:0]         out_region
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int XW = plc_pkg::X_W;
  localparam int YW = plc_pkg::Y_W;

  plc_pkg::plc_state_t state_r, state_nxt;

  logic [plc_pkg::CNT_W-1:0]  pts_r;
  logic [AW-1:0]              last_cfg;

  logic [XW-1:0]              mem_x [MAX_POINTS];
  logic signed [YW-1:0]       mem_y [MAX_POINTS];
  logic [XW-1:0]              rd_x_q;
  logic signed [YW-1:0]       rd_y_q;
  logic [AW-1:0]              rd_addr;
  logic                       mem_we;
  logic                       in_fire;

  logic [XW-1:0]              qx_r, qx_nxt;
  logic [AW-1:0]              last_r, last_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [XW-1:0]              lastx_r, lastx_nxt;
  logic signed [YW-1:0]       lasty_r, lasty_nxt;
  logic [XW-1:0]              prevx_r, prevx_nxt;
  logic signed [YW-1:0]       prevy_r, prevy_nxt;
  logic signed [YW-1:0]       base_y_r, base_y_nxt;
  logic [AW-1:0]              seg_r, seg_nxt;
  logic [plc_pkg::REG_W-1:0]  region_r, region_nxt;
  logic signed [plc_pkg::DY_W-1:0]   dy_r, dy_nxt;
  logic [XW-1:0]              dxq_r, dxq_nxt;
  logic [XW-1:0]              dx_r, dx_nxt;
  logic signed [plc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [plc_pkg::PROD_W-1:0] prod_abs;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [YW-1:0]       out_y_r, out_y_nxt;
  logic [plc_pkg::IDX_W-1:0]  out_seg_r, out_seg_nxt;
  logic [plc_pkg::REG_W-1:0]  out_reg_r, out_reg_nxt;

  logic                       below_w, above_w, hit_w, out_free;
  logic                       div_start, div_done;
  logic [plc_pkg::Q_W-1:0]    quo;
  logic signed [plc_pkg::DY_W-1:0] q_s;
  logic signed [plc_pkg::DY_W-1:0] sum_w;

  assign in_ready = (state_r == plc_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign mem_we   = in_fire && (in_command == plc_pkg::CMD_LOAD) &&
                    (32'(in_point_index) < MAX_POINTS);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (pts_r == '0) begin
      last_cfg = '0;
    end else if (32'(pts_r) > MAX_POINTS) begin
      last_cfg = AW'(MAX_POINTS - 1);
    end else begin
      last_cfg = AW'(pts_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[AW'(in_point_index)] <= in_point_x;
      mem_y[AW'(in_point_index)] <= in_point_y;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  assign below_w = qx_r <= rd_x_q;
  assign above_w = qx_r > lastx_r;
  assign hit_w   = (prevx_r < qx_r) && (qx_r <= rd_x_q);

  assign prod_abs = prod_r[plc_pkg::PROD_W-1] ? plc_pkg::PROD_W'(-prod_r) : prod_r;
  assign q_s      = prod_r[plc_pkg::PROD_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum_w    = $signed({base_y_r[YW-1], base_y_r}) +
                    ((region_r == plc_pkg::REGION_INSIDE) ? q_s : '0);

  plc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_abs[plc_pkg::DVD_W-1:0]),
    .divisor  (dx_r),
    .done     (div_done),
    .quotient (quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plc_pkg::ST_IDLE: begin
        if (in_fire && in_command == plc_pkg::CMD_QUERY) state_nxt = plc_pkg::ST_RD_LAST;
      end
      plc_pkg::ST_RD_LAST:   state_nxt = plc_pkg::ST_CHK_FIRST;
      plc_pkg::ST_CHK_FIRST: begin
        state_nxt = (below_w || above_w) ? plc_pkg::ST_FIN : plc_pkg::ST_SCAN;
      end
      plc_pkg::ST_SCAN: begin
        if (hit_w || idx_r == last_r) state_nxt = plc_pkg::ST_MUL;
      end
      plc_pkg::ST_MUL:       state_nxt = plc_pkg::ST_DIV_START;
      plc_pkg::ST_DIV_START: state_nxt = plc_pkg::ST_DIV_WAIT;
      plc_pkg::ST_DIV_WAIT: begin
        if (div_done) state_nxt = plc_pkg::ST_FIN;
      end
      plc_pkg::ST_FIN: begin
        if (out_free) state_nxt = plc_pkg::ST_IDLE;
      end
      default: state_nxt = plc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    qx_nxt        = qx_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    lastx_nxt     = lastx_r;
    lasty_nxt     = lasty_r;
    prevx_nxt     = prevx_r;
    prevy_nxt     = prevy_r;
    base_y_nxt    = base_y_r;
    seg_nxt       = seg_r;
    region_nxt    = region_r;
    dy_nxt        = dy_r;
    dxq_nxt       = dxq_r;
    dx_nxt        = dx_r;
    prod_nxt      = prod_r;
    div_start     = 1'b0;
    rd_addr       = AW'(idx_r + 1'b1);
    out_valid_nxt = out_valid_r && !out_ready;
    out_y_nxt     = out_y_r;
    out_seg_nxt   = out_seg_r;
    out_reg_nxt   = out_reg_r;
    unique case (state_r)
      plc_pkg::ST_IDLE: begin
        rd_addr = last_cfg;
        if (in_fire && in_command == plc_pkg::CMD_QUERY) begin
          qx_nxt   = in_query_x;
          last_nxt = last_cfg;
        end
      end
      plc_pkg::ST_RD_LAST: begin
        lastx_nxt = rd_x_q;
        lasty_nxt = rd_y_q;
        rd_addr   = '0;
      end
      plc_pkg::ST_CHK_FIRST: begin
        prevx_nxt  = rd_x_q;
        prevy_nxt  = rd_y_q;
        idx_nxt    = AW'(1);
        rd_addr    = AW'(1);
        region_nxt = plc_pkg::REGION_INSIDE;
        if (below_w) begin
          base_y_nxt = rd_y_q;
          seg_nxt    = '0;
          region_nxt = plc_pkg::REGION_BELOW;
        end else if (above_w) begin
          base_y_nxt = lasty_r;
          seg_nxt    = last_r;
          region_nxt = plc_pkg::REGION_ABOVE;
        end
      end
      plc_pkg::ST_SCAN: begin
        if (hit_w || idx_r == last_r) begin
          seg_nxt    = AW'(idx_r - 1'b1);
          base_y_nxt = prevy_r;
          dy_nxt     = $signed({rd_y_q[YW-1], rd_y_q}) - $signed({prevy_r[YW-1], prevy_r});
          dxq_nxt    = qx_r - prevx_r;
          dx_nxt     = rd_x_q - prevx_r;
        end else begin
          prevx_nxt = rd_x_q;
          prevy_nxt = rd_y_q;
          idx_nxt   = AW'(idx_r + 1'b1);
        end
      end
      plc_pkg::ST_MUL: begin
        prod_nxt = plc_pkg::PROD_W'(dy_r) * plc_pkg::PROD_W'($signed({1'b0, dxq_r}));
      end
      plc_pkg::ST_DIV_START: begin
        div_start = 1'b1;
      end
      plc_pkg::ST_DIV_WAIT: begin
      end
      plc_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = sum_w[YW-1:0];
          out_seg_nxt   = plc_pkg::IDX_W'(seg_r);
          out_reg_nxt   = region_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plc_pkg::ST_IDLE;
      pts_r       <= plc_pkg::CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        pts_r <= cfg_wdata;
      end
    end
    qx_r      <= qx_nxt;
    last_r    <= last_nxt;
    idx_r     <= idx_nxt;
    lastx_r   <= lastx_nxt;
    lasty_r   <= lasty_nxt;
    prevx_r   <= prevx_nxt;
    prevy_r   <= prevy_nxt;
    base_y_r  <= base_y_nxt;
    seg_r     <= seg_nxt;
    region_r  <= region_nxt;
    dy_r      <= dy_nxt;
    dxq_r     <= dxq_nxt;
    dx_r      <= dx_nxt;
    prod_r    <= prod_nxt;
    out_y_r   <= out_y_nxt;
    out_seg_r <= out_seg_nxt;
    out_reg_r <= out_reg_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_result_y = out_y_r;
  assign out_segment  = out_seg_r;
  assign out_region   = out_reg_r;

endmodule

// ===== sv/plc_checker.sv =====
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks for the piecewise linear calibration block.
// ----------------------------------------------------------------------------
module plc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_command,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [plc_pkg::Y_W-1:0]    out_result_y,
  input logic [plc_pkg::IDX_W-1:0]         out_segment,
  input logic [plc_pkg::REG_W-1:0]         out_region
);

  // a query occupies the sequencer
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == plc_pkg::CMD_QUERY |=> !in_ready)
    else $error("input taken right after a query item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_y) &&
      $stable(out_segment) && $stable(out_region))
    else $error("result item changed while stalled");

  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_region == plc_pkg::REGION_BELOW ||
      out_region == plc_pkg::REGION_INSIDE || out_region == plc_pkg::REGION_ABOVE)
    else $error("bad region code");

  a_below_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == plc_pkg::REGION_BELOW |-> out_segment == '0)
    else $error("below-table result with nonzero segment");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind piecewise_linear_calibration plc_checker u_plc_checker (.*);
